// ===== rtl/core/mep_pkg.sv =====
// ----------------------------------------------------------------------------
// mep_pkg: shared types and constants for the Mandelbrot escape-time pixel
// Holds the register map, the controller states, the command and status
// words between controller and datapath, and the Q4.60 saturation helper.
// ----------------------------------------------------------------------------
package mep_pkg;

	// Pixel coordinate width.
	localparam int COORD_BITS = 12;

	// Fixed-point format: signed Q4.60 in 64 bits.
	localparam int Q_FRAC  = 60;
	localparam int ESC_LSB = 2 * Q_FRAC + 2;

	// Register map, indexed by paddr[5:3].
	localparam logic [2:0] REG_ORIGIN_RE = 3'd0;
	localparam logic [2:0] REG_ORIGIN_IM = 3'd1;
	localparam logic [2:0] REG_STEP_RE   = 3'd2;
	localparam logic [2:0] REG_STEP_IM   = 3'd3;
	localparam logic [2:0] REG_MAX_ITER  = 3'd4;

	// Register reset values.
	localparam logic [63:0] ORIGIN_RE_RST = 64'hD800_0000_0000_0000;
	localparam logic [63:0] ORIGIN_IM_RST = 64'hEC00_0000_0000_0000;
	localparam logic [62:0] STEP_RE_RST   = 63'd2401919801264264;
	localparam logic [62:0] STEP_IM_RST   = 63'd2401919801264264;
	localparam logic [15:0] MAX_ITER_RST  = 16'd2000;

	// Color levels.
	localparam logic [7:0] COLOR_FULL = 8'hFF;
	localparam logic [7:0] COLOR_NONE = 8'h00;

	// Divider runs one quotient bit per step.
	localparam logic [2:0] DIV_LAST = 3'd7;

	typedef struct packed {
		logic [63:0] origin_re;
		logic [63:0] origin_im;
		logic [62:0] step_re;
		logic [62:0] step_im;
		logic [15:0] max_iter;
	} mep_cfg_t;

	typedef enum logic [2:0] {
		MSEL_PX,
		MSEL_PY,
		MSEL_XX,
		MSEL_YY,
		MSEL_XY
	} mep_msel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MAP0,
		ST_MAP1,
		ST_MAP2,
		ST_MAP3,
		ST_MAGS,
		ST_SQ0,
		ST_SQ1,
		ST_SQ2,
		ST_SQ3,
		ST_SQ4,
		ST_EVAL,
		ST_DIV,
		ST_FINISH
	} mep_state_t;

	typedef struct packed {
		logic      load_pix;
		mep_msel_t msel;
		logic      cap_cx;
		logic      cap_cy;
		logic      cap_mag;
		logic      cap_xx;
		logic      cap_yy;
		logic      cap_eval;
		logic      upd_z;
		logic      div_init;
		logic      div_step;
		logic      load_out;
	} mep_cmd_t;

	typedef struct packed {
		logic esc;
		logic at_limit;
	} mep_stat_t;

	// Clamp a 128-bit two's complement value into the signed 64-bit range.
	function automatic logic [63:0] sat128(input logic [127:0] v);
		logic [63:0] r;
		if (v[127:63] == {65{v[127]}}) begin
			r = v[63:0];
		end else if (v[127]) begin
			r = {1'b1, {63{1'b0}}};
		end else begin
			r = {1'b0, {63{1'b1}}};
		end
		return r;
	endfunction

endpackage

// ===== rtl/core/mep_if.sv =====
// ----------------------------------------------------------------------------
// mep_if: valid/ready channels of the escape-time pixel
// The pixel channel carries one coordinate word, the color channel one
// result word.
// ----------------------------------------------------------------------------
interface mep_pixel_if;
	logic                           valid;
	logic                           ready;
	logic [mep_pkg::COORD_BITS-1:0] pixel_x;
	logic [mep_pkg::COORD_BITS-1:0] pixel_y;

	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mep_color_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [15:0] iterations;
	logic        escaped;

	modport source (output valid, output red, output green, output blue,
		output iterations, output escaped, input ready);
	modport sink (input valid, input red, input green, input blue,
		input iterations, input escaped, output ready);
endinterface

// ===== rtl/core/mep_mul64.sv =====
// ----------------------------------------------------------------------------
// mep_mul64: two-stage 64 x 64 unsigned multiplier
// Stage one forms four 32 x 32 partial products, stage two sums them into
// the full 128-bit product.
// ----------------------------------------------------------------------------
module mep_mul64 (
	input  logic         clk,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic [127:0] prod
);

	logic [63:0]  ll_s1;
	logic [63:0]  lh_s1;
	logic [63:0]  hl_s1;
	logic [63:0]  hh_s1;
	logic [127:0] prod_s2;

	// Partial products of the 32-bit halves.
	always_ff @(posedge clk) begin
		ll_s1 <= a[31:0] * b[31:0];
		lh_s1 <= a[31:0] * b[63:32];
		hl_s1 <= a[63:32] * b[31:0];
		hh_s1 <= a[63:32] * b[63:32];
	end

	// Align and sum the partial products.
	always_ff @(posedge clk) begin
		prod_s2 <= {64'd0, ll_s1} + {32'd0, lh_s1, 32'd0} + {32'd0, hl_s1, 32'd0}
			+ {hh_s1, 64'd0};
	end

	assign prod = prod_s2;

endmodule

// ===== rtl/core/mep_datapath.sv =====
// ----------------------------------------------------------------------------
// mep_datapath: arithmetic of the escape-time pixel
// Maps the coordinate to c, iterates z = z*z + c on a shared multiplier,
// runs the bit-serial color divider and holds the output word.
// ----------------------------------------------------------------------------
module mep_datapath (
	input  logic                           clk,
	input  mep_pkg::mep_cfg_t              cfg,
	input  mep_pkg::mep_cmd_t              cmd,
	output mep_pkg::mep_stat_t             stat,
	input  logic [mep_pkg::COORD_BITS-1:0] pixel_x,
	input  logic [mep_pkg::COORD_BITS-1:0] pixel_y,
	output logic [7:0]                     red,
	output logic [7:0]                     green,
	output logic [7:0]                     blue,
	output logic [15:0]                    iterations,
	output logic                           escaped
);

	logic [mep_pkg::COORD_BITS-1:0] px_q;
	logic [mep_pkg::COORD_BITS-1:0] py_q;
	logic [63:0]  cx_q;
	logic [63:0]  cy_q;
	logic [63:0]  zx_q;
	logic [63:0]  zy_q;
	logic [63:0]  magx_q;
	logic [63:0]  magy_q;
	logic         sgn_q;
	logic [127:0] xx_q;
	logic [127:0] yy_q;
	logic [67:0]  re_q;
	logic [68:0]  im_q;
	logic         esc_q;
	logic [15:0]  iter_q;
	logic [15:0]  rem_q;
	logic [7:0]   quot_q;
	logic [7:0]   red_q;
	logic [7:0]   green_q;
	logic [7:0]   blue_q;
	logic [15:0]  iter_out_q;
	logic         esc_out_q;

	logic [63:0]  mul_a;
	logic [63:0]  mul_b;
	logic [127:0] prod;
	logic [127:0] sq_sum;
	logic [127:0] sq_diff;
	logic [127:0] xy_signed;
	logic [16:0]  div_trial;
	logic [16:0]  div_diff;
	logic         div_ge;

	// Multiplier operand selection.
	always_comb begin
		case (cmd.msel)
			mep_pkg::MSEL_PX: begin
				mul_a = {{(64 - mep_pkg::COORD_BITS){1'b0}}, px_q};
				mul_b = {1'b0, cfg.step_re};
			end
			mep_pkg::MSEL_PY: begin
				mul_a = {{(64 - mep_pkg::COORD_BITS){1'b0}}, py_q};
				mul_b = {1'b0, cfg.step_im};
			end
			mep_pkg::MSEL_XX: begin
				mul_a = magx_q;
				mul_b = magx_q;
			end
			mep_pkg::MSEL_YY: begin
				mul_a = magy_q;
				mul_b = magy_q;
			end
			mep_pkg::MSEL_XY: begin
				mul_a = magx_q;
				mul_b = magy_q;
			end
			default: begin
				mul_a = 64'd0;
				mul_b = 64'd0;
			end
		endcase
	end

	mep_mul64 u_mul (
		.clk  (clk),
		.a    (mul_a),
		.b    (mul_b),
		.prod (prod)
	);

	// Square terms for the escape test and the next z.
	assign sq_sum    = xx_q + yy_q;
	assign sq_diff   = xx_q - yy_q;
	assign xy_signed = sgn_q ? (128'd0 - prod) : prod;

	// One restoring divider step on the constant dividend 255.
	assign div_trial = {rem_q, 1'b1};
	assign div_diff  = div_trial - {1'b0, iter_q};
	assign div_ge    = !div_diff[16];

	// Coordinate capture and point mapping.
	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			px_q <= pixel_x;
			py_q <= pixel_y;
		end
		if (cmd.cap_cx) begin
			cx_q <= mep_pkg::sat128(prod + {{64{cfg.origin_re[63]}}, cfg.origin_re});
		end
		if (cmd.cap_cy) begin
			cy_q <= mep_pkg::sat128(prod + {{64{cfg.origin_im[63]}}, cfg.origin_im});
		end
	end

	// Iteration state: z, its magnitudes, the squares and the iteration count.
	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			zx_q   <= 64'd0;
			zy_q   <= 64'd0;
			iter_q <= 16'd0;
		end else if (cmd.upd_z) begin
			zx_q   <= mep_pkg::sat128({{60{re_q[67]}}, re_q} + {{64{cx_q[63]}}, cx_q});
			zy_q   <= mep_pkg::sat128({{59{im_q[68]}}, im_q} + {{64{cy_q[63]}}, cy_q});
			iter_q <= iter_q + 16'd1;
		end
		if (cmd.cap_mag) begin
			magx_q <= zx_q[63] ? (64'd0 - zx_q) : zx_q;
			magy_q <= zy_q[63] ? (64'd0 - zy_q) : zy_q;
			sgn_q  <= zx_q[63] ^ zy_q[63];
		end
		if (cmd.cap_xx) begin
			xx_q <= prod;
		end
		if (cmd.cap_yy) begin
			yy_q <= prod;
		end
		if (cmd.cap_eval) begin
			esc_q <= |sq_sum[127:mep_pkg::ESC_LSB];
			re_q  <= sq_diff[127:mep_pkg::Q_FRAC];
			im_q  <= xy_signed[127:mep_pkg::Q_FRAC-1];
		end
	end

	// Divider for the red level, one quotient bit per step.
	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			rem_q  <= 16'd0;
			quot_q <= 8'd0;
		end else if (cmd.div_step) begin
			rem_q  <= div_ge ? div_diff[15:0] : div_trial[15:0];
			quot_q <= {quot_q[6:0], div_ge};
		end
	end

	// Output word.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			red_q      <= esc_q ? (mep_pkg::COLOR_FULL - quot_q) : mep_pkg::COLOR_FULL;
			green_q    <= esc_q ? mep_pkg::COLOR_NONE : mep_pkg::COLOR_FULL;
			blue_q     <= esc_q ? mep_pkg::COLOR_NONE : mep_pkg::COLOR_FULL;
			iter_out_q <= iter_q;
			esc_out_q  <= esc_q;
		end
	end

	assign stat.esc      = esc_q;
	assign stat.at_limit = (iter_q >= cfg.max_iter);

	assign red        = red_q;
	assign green      = green_q;
	assign blue       = blue_q;
	assign iterations = iter_out_q;
	assign escaped    = esc_out_q;

endmodule

// ===== rtl/core/mep_ctrl.sv =====
// ----------------------------------------------------------------------------
// mep_ctrl: sequencer of the escape-time pixel
// Steps the datapath through mapping, the iteration passes and the color
// divider, and owns the channel handshakes.
// ----------------------------------------------------------------------------
module mep_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	input  mep_pkg::mep_stat_t stat,
	output mep_pkg::mep_cmd_t  cmd
);

	mep_pkg::mep_state_t state_q;
	mep_pkg::mep_state_t state_d;
	logic [2:0]          cnt_q;
	logic                out_valid_q;
	logic                out_free;

	assign out_free = !out_valid_q || out_ready;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mep_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			mep_pkg::ST_IDLE: begin
				if (in_valid) state_d = mep_pkg::ST_MAP0;
			end
			mep_pkg::ST_MAP0:  state_d = mep_pkg::ST_MAP1;
			mep_pkg::ST_MAP1:  state_d = mep_pkg::ST_MAP2;
			mep_pkg::ST_MAP2:  state_d = mep_pkg::ST_MAP3;
			mep_pkg::ST_MAP3:  state_d = mep_pkg::ST_MAGS;
			mep_pkg::ST_MAGS:  state_d = mep_pkg::ST_SQ0;
			mep_pkg::ST_SQ0:   state_d = mep_pkg::ST_SQ1;
			mep_pkg::ST_SQ1:   state_d = mep_pkg::ST_SQ2;
			mep_pkg::ST_SQ2:   state_d = mep_pkg::ST_SQ3;
			mep_pkg::ST_SQ3:   state_d = mep_pkg::ST_SQ4;
			mep_pkg::ST_SQ4:   state_d = mep_pkg::ST_EVAL;
			mep_pkg::ST_EVAL: begin
				if (stat.esc) begin
					state_d = mep_pkg::ST_DIV;
				end else if (stat.at_limit) begin
					state_d = mep_pkg::ST_FINISH;
				end else begin
					state_d = mep_pkg::ST_MAGS;
				end
			end
			mep_pkg::ST_DIV: begin
				if (cnt_q == mep_pkg::DIV_LAST) state_d = mep_pkg::ST_FINISH;
			end
			mep_pkg::ST_FINISH: begin
				if (out_free) state_d = mep_pkg::ST_IDLE;
			end
			default: state_d = mep_pkg::ST_IDLE;
		endcase
	end

	// Datapath commands.
	always_comb begin
		cmd      = '0;
		cmd.msel = mep_pkg::MSEL_XX;
		in_ready = 1'b0;
		case (state_q)
			mep_pkg::ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_pix = in_valid;
			end
			mep_pkg::ST_MAP0: cmd.msel = mep_pkg::MSEL_PX;
			mep_pkg::ST_MAP1: cmd.msel = mep_pkg::MSEL_PY;
			mep_pkg::ST_MAP2: cmd.cap_cx = 1'b1;
			mep_pkg::ST_MAP3: cmd.cap_cy = 1'b1;
			mep_pkg::ST_MAGS: cmd.cap_mag = 1'b1;
			mep_pkg::ST_SQ0:  cmd.msel = mep_pkg::MSEL_XX;
			mep_pkg::ST_SQ1:  cmd.msel = mep_pkg::MSEL_YY;
			mep_pkg::ST_SQ2: begin
				cmd.msel   = mep_pkg::MSEL_XY;
				cmd.cap_xx = 1'b1;
			end
			mep_pkg::ST_SQ3:  cmd.cap_yy = 1'b1;
			mep_pkg::ST_SQ4:  cmd.cap_eval = 1'b1;
			mep_pkg::ST_EVAL: begin
				cmd.div_init = stat.esc;
				cmd.upd_z    = !stat.esc && !stat.at_limit;
			end
			mep_pkg::ST_DIV:    cmd.div_step = 1'b1;
			mep_pkg::ST_FINISH: cmd.load_out = out_free;
			default: ;
		endcase
	end

	// Divider step counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 3'd0;
		end else if (cmd.div_init) begin
			cnt_q <= 3'd0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 3'd1;
		end
	end

	// Output word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/core/mandelbrot_escape_pixel.sv =====
// After accepting a pixel, the controller maps it to c, runs iteration passes until
// z escapes or the limit is reached, and runs the divider for an escaped pixel.
// One pixel is in work at a time; the next is taken only in idle, after the word is queued.
// Each pass runs three 64 x 64 products on the shared multiplier.
// Reset returns the controller to idle and the view registers to their defaults;
// datapath registers are not reset and there is no clearing pass.
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel: escape-time color of one pixel
// Maps a pixel coordinate to a point c in Q4.60, iterates z = z*z + c and
// returns the red level, the white flag colors and the iteration count.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	mep_pixel_if.sink   pix,
	mep_color_if.source color
);

	mep_pkg::mep_cfg_t  cfg_q;
	mep_pkg::mep_cmd_t  cmd;
	mep_pkg::mep_stat_t stat;
	logic               wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_re <= mep_pkg::ORIGIN_RE_RST;
			cfg_q.origin_im <= mep_pkg::ORIGIN_IM_RST;
			cfg_q.step_re   <= mep_pkg::STEP_RE_RST;
			cfg_q.step_im   <= mep_pkg::STEP_IM_RST;
			cfg_q.max_iter  <= mep_pkg::MAX_ITER_RST;
		end else if (wr_en) begin
			case (paddr[5:3])
				mep_pkg::REG_ORIGIN_RE: cfg_q.origin_re <= pwdata;
				mep_pkg::REG_ORIGIN_IM: cfg_q.origin_im <= pwdata;
				mep_pkg::REG_STEP_RE:   cfg_q.step_re   <= pwdata[62:0];
				mep_pkg::REG_STEP_IM:   cfg_q.step_im   <= pwdata[62:0];
				mep_pkg::REG_MAX_ITER:  cfg_q.max_iter  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (paddr[5:3])
			mep_pkg::REG_ORIGIN_RE: prdata = cfg_q.origin_re;
			mep_pkg::REG_ORIGIN_IM: prdata = cfg_q.origin_im;
			mep_pkg::REG_STEP_RE:   prdata = {1'b0, cfg_q.step_re};
			mep_pkg::REG_STEP_IM:   prdata = {1'b0, cfg_q.step_im};
			mep_pkg::REG_MAX_ITER:  prdata = {48'd0, cfg_q.max_iter};
			default:                prdata = 64'd0;
		endcase
	end

	mep_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pix.valid),
		.in_ready  (pix.ready),
		.out_valid (color.valid),
		.out_ready (color.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	mep_datapath u_datapath (
		.clk        (clk),
		.cfg        (cfg_q),
		.cmd        (cmd),
		.stat       (stat),
		.pixel_x    (pix.pixel_x),
		.pixel_y    (pix.pixel_y),
		.red        (color.red),
		.green      (color.green),
		.blue       (color.blue),
		.iterations (color.iterations),
		.escaped    (color.escaped)
	);

endmodule

// ===== bench/tb_mandelbrot_escape_pixel.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_pixel: self-checking bench for the escape-time pixel
// Programs the view over the register port, sends pixel words with random
// gaps and checks every color word against a Q4.60 escape-time predictor
// kept in step with the register writes.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_pixel;

	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 100;
	localparam int IDLE_PCT    = 29;

	// 4.0 expressed on the scale of a squared Q4.60 value.
	localparam logic [127:0] ESCAPE_BOUND = 128'd1 << 122;
	localparam logic signed [127:0] Q_MAX = {65'd0, {63{1'b1}}};
	localparam logic signed [127:0] Q_MIN = {{65{1'b1}}, 63'd0};

	// A point near the seahorse valley, about -0.75 + 0.1i.
	localparam logic [63:0] ZOOM_RE = -64'sd864691128455135232;
	localparam logic [63:0] ZOOM_IM = 64'd115292150460684698;

	typedef struct packed {
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [15:0] iterations;
		logic        escaped;
	} color_word_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	mep_pixel_if pix_ch ();
	mep_color_if color_ch ();

	mandelbrot_escape_pixel u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix     (pix_ch),
		.color   (color_ch)
	);

	// View registers as the block should hold them.
	mep_pkg::mep_cfg_t view_cfg;
	color_word_t       expected_colors[$];
	color_word_t       chk_got;
	color_word_t       chk_want;
	int                color_errors = 0;
	int                words_seen = 0;
	int                cycle_count = 0;
	bit                src_idle_en = 1'b1;
	bit                snk_idle_en = 1'b1;
	int                hold_req = 0;

	// Clock.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Run-away guard.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Escape-time predictor
	// ------------------------------------------------------------------

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Clamp an exact value into the Q4.60 range.
	function automatic logic signed [63:0] clamp_q460(input logic signed [127:0] v);
		if (v > Q_MAX) begin
			return Q_MAX[63:0];
		end
		if (v < Q_MIN) begin
			return Q_MIN[63:0];
		end
		return v[63:0];
	endfunction

	// Exact square of the magnitude of a Q4.60 value.
	function automatic logic [127:0] mag_sq(input logic signed [63:0] v);
		logic [127:0] m;
		m = {64'd0, (v[63] ? (~v + 64'd1) : v)};
		return m * m;
	endfunction

	function automatic bit is_escaped_q(input logic signed [63:0] zx,
			input logic signed [63:0] zy);
		return (mag_sq(zx) + mag_sq(zy)) >= ESCAPE_BOUND;
	endfunction

	function automatic color_word_t escape_color(input logic [mep_pkg::COORD_BITS-1:0] px,
			input logic [mep_pkg::COORD_BITS-1:0] py);
		logic [127:0]        offs;
		logic signed [127:0] org;
		logic signed [127:0] cx_w;
		logic signed [127:0] cy_w;
		logic signed [127:0] zr_w;
		logic signed [127:0] zi_w;
		logic signed [127:0] sq_re;
		logic signed [127:0] xy_w;
		logic signed [63:0]  zx;
		logic signed [63:0]  zy;
		logic [16:0]         n;
		int unsigned         quot;
		color_word_t         w;

		// Map the coordinate onto the complex plane.
		offs = 128'(px) * 128'(view_cfg.step_re);
		org  = $signed(view_cfg.origin_re);
		cx_w = clamp_q460($signed(offs) + org);
		offs = 128'(py) * 128'(view_cfg.step_im);
		org  = $signed(view_cfg.origin_im);
		cy_w = clamp_q460($signed(offs) + org);

		// Iterate z = z*z + c with floor truncation back to Q4.60.
		zx = '0;
		zy = '0;
		n  = '0;
		while (n < {1'b0, view_cfg.max_iter} && !is_escaped_q(zx, zy)) begin
			zr_w  = zx;
			zi_w  = zy;
			sq_re = (zr_w * zr_w - zi_w * zi_w) >>> 60;
			xy_w  = (zr_w * zi_w) >>> 59;
			zx    = clamp_q460(sq_re + cx_w);
			zy    = clamp_q460(xy_w + cy_w);
			n++;
		end

		// Escaped points shade red by iteration count, the rest are white.
		if (is_escaped_q(zx, zy) && n != 0) begin
			quot    = 255 / n;
			w.red   = 8'(255 - quot);
			w.green = mep_pkg::COLOR_NONE;
			w.blue  = mep_pkg::COLOR_NONE;
			w.escaped = 1'b1;
		end else begin
			w.red   = mep_pkg::COLOR_FULL;
			w.green = mep_pkg::COLOR_FULL;
			w.blue  = mep_pkg::COLOR_FULL;
			w.escaped = 1'b0;
		end
		w.iterations = n[15:0];
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Color word sink and checker
	// ------------------------------------------------------------------

	// Ready with random stalls; a hold request parks the sink for a long stretch.
	initial begin
		int hold_seen;
		int hold_left;
		hold_seen = 0;
		hold_left = 0;
		color_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				color_ch.ready <= 1'b0;
			end else begin
				color_ch.ready <= !(snk_idle_en && $urandom_range(0, 99) < IDLE_PCT);
			end
		end
	end

	// Compare each accepted word with the oldest prediction.
	always @(posedge clk) begin
		if (color_ch.valid && color_ch.ready) begin
			chk_got = {color_ch.red, color_ch.green, color_ch.blue,
				color_ch.iterations, color_ch.escaped};
			if (expected_colors.size() == 0) begin
				color_errors++;
				if (color_errors <= 10) begin
					$display("color word %0d: expected none, got r=%0d g=%0d b=%0d it=%0d esc=%0b",
						words_seen, chk_got.red, chk_got.green, chk_got.blue,
						chk_got.iterations, chk_got.escaped);
				end
			end else begin
				chk_want = expected_colors.pop_front();
				if (chk_got !== chk_want) begin
					color_errors++;
					if (color_errors <= 10) begin
						$display("color word %0d: expected r=%0d g=%0d b=%0d it=%0d esc=%0b",
							words_seen, chk_want.red, chk_want.green, chk_want.blue,
							chk_want.iterations, chk_want.escaped);
						$display("color word %0d:      got r=%0d g=%0d b=%0d it=%0d esc=%0b",
							words_seen, chk_got.red, chk_got.green, chk_got.blue,
							chk_got.iterations, chk_got.escaped);
					end
				end
			end
			words_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------

	// One register write; psel stays high so writes can run back to back.
	task automatic apb_write(input logic [2:0] idx, input logic [63:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 3'b000};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			mep_pkg::REG_ORIGIN_RE: view_cfg.origin_re = data;
			mep_pkg::REG_ORIGIN_IM: view_cfg.origin_im = data;
			mep_pkg::REG_STEP_RE:   view_cfg.step_re   = data[62:0];
			mep_pkg::REG_STEP_IM:   view_cfg.step_im   = data[62:0];
			mep_pkg::REG_MAX_ITER:  view_cfg.max_iter  = data[15:0];
			default: ;
		endcase
	endtask

	task automatic program_view(input mep_pkg::mep_cfg_t cfg);
		apb_write(mep_pkg::REG_ORIGIN_RE, cfg.origin_re);
		apb_write(mep_pkg::REG_ORIGIN_IM, cfg.origin_im);
		apb_write(mep_pkg::REG_STEP_RE, {1'b0, cfg.step_re});
		apb_write(mep_pkg::REG_STEP_IM, {1'b0, cfg.step_im});
		apb_write(mep_pkg::REG_MAX_ITER, {48'd0, cfg.max_iter});
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Offer one pixel word and record its predicted color once taken.
	task automatic send_pixel(input logic [mep_pkg::COORD_BITS-1:0] px,
			input logic [mep_pkg::COORD_BITS-1:0] py);
		color_word_t want;
		want = escape_color(px, py);
		while (src_idle_en && $urandom_range(0, 99) < IDLE_PCT) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
		end
		pix_ch.valid   <= 1'b1;
		pix_ch.pixel_x <= px;
		pix_ch.pixel_y <= py;
		do @(posedge clk); while (!pix_ch.ready);
		expected_colors.push_back(want);
	endtask

	// Stop offering and wait until every predicted word has come back.
	task automatic drain();
		pix_ch.valid <= 1'b0;
		while (expected_colors.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// ------------------------------------------------------------------
	// View generators
	// ------------------------------------------------------------------

	// Around the default full view, a few thousand pixels wide.
	function automatic mep_pkg::mep_cfg_t classic_view(input int iter_lo, input int iter_hi);
		mep_pkg::mep_cfg_t cfg;
		cfg.origin_re = mep_pkg::ORIGIN_RE_RST + ($signed(rand64()) >>> 4);
		cfg.origin_im = mep_pkg::ORIGIN_IM_RST + ($signed(rand64()) >>> 4);
		cfg.step_re   = 63'((64'd1 << 48) + (rand64() >> 14));
		cfg.step_im   = 63'((64'd1 << 48) + (rand64() >> 14));
		cfg.max_iter  = 16'($urandom_range(iter_lo, iter_hi));
		return cfg;
	endfunction

	// A deep zoom onto the set boundary.
	function automatic mep_pkg::mep_cfg_t zoom_view();
		mep_pkg::mep_cfg_t cfg;
		cfg.origin_re = ZOOM_RE + ($signed(rand64()) >>> 12);
		cfg.origin_im = ZOOM_IM + ($signed(rand64()) >>> 12);
		cfg.step_re   = 63'((64'd1 << 38) + (rand64() >> 26));
		cfg.step_im   = 63'((64'd1 << 38) + (rand64() >> 26));
		cfg.max_iter  = 16'($urandom_range(40, 64));
		return cfg;
	endfunction

	// Any origin and step content; most points land far outside and saturate.
	function automatic mep_pkg::mep_cfg_t wild_view();
		mep_pkg::mep_cfg_t cfg;
		cfg.origin_re = rand64();
		cfg.origin_im = rand64();
		cfg.step_re   = 63'(rand64());
		cfg.step_im   = 63'(rand64());
		cfg.max_iter  = 16'($urandom_range(1, 32));
		return cfg;
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Reset view: corners escape, the middle of the main cardioid stays white.
	task automatic test_reset_view();
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd960, 12'd600);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		drain();
	endtask

	// Register and coordinate extremes, including mapping saturation
	// and a zero iteration limit.
	task automatic test_field_extremes();
		mep_pkg::mep_cfg_t cfg;
		cfg.origin_re = {1'b1, 63'd0};
		cfg.origin_im = {1'b0, {63{1'b1}}};
		cfg.step_re   = {63{1'b1}};
		cfg.step_im   = {63{1'b1}};
		cfg.max_iter  = 16'hFFFF;
		program_view(cfg);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd1, 12'd1);
		drain();

		cfg.origin_re = {1'b0, {63{1'b1}}};
		cfg.origin_im = {1'b1, 63'd0};
		cfg.step_re   = '0;
		cfg.step_im   = '0;
		cfg.max_iter  = '0;
		program_view(cfg);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd4095, 12'd4095);
		drain();
	endtask

	// Points exactly on |z| = 2 escape; one step inside does not.
	task automatic test_escape_boundary();
		mep_pkg::mep_cfg_t cfg;
		cfg.origin_re = -64'sd2305843009213693952;
		cfg.origin_im = -64'sd2305843009213693952;
		cfg.step_re   = 63'd1;
		cfg.step_im   = 63'd1 << 60;
		cfg.max_iter  = 16'd16;
		program_view(cfg);
		send_pixel(12'd0, 12'd2);
		send_pixel(12'd1, 12'd2);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd0, 12'd4);
		send_pixel(12'd4095, 12'd3);
		drain();
	endtask

	// A limit of one pass: c = 0 and c = 1 stay white, c = 2 escapes at once.
	task automatic test_single_pass();
		mep_pkg::mep_cfg_t cfg;
		cfg.origin_re = '0;
		cfg.origin_im = '0;
		cfg.step_re   = 63'd1 << 60;
		cfg.step_im   = '0;
		cfg.max_iter  = 16'd1;
		program_view(cfg);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd0);
		send_pixel(12'd2, 12'd0);
		drain();
	endtask

	// The sink parks while pixels keep coming, so the input stalls.
	task automatic test_backpressure();
		program_view(classic_view(4, 8));
		hold_req++;
		repeat (8) begin
			send_pixel(12'($urandom()), 12'($urandom()));
		end
		drain();
	endtask

	task automatic test_random_pixels(input mep_pkg::mep_cfg_t cfg, input int count);
		program_view(cfg);
		repeat (count) begin
			send_pixel(12'($urandom()), 12'($urandom()));
		end
		drain();
	endtask

	// Full-rate stretch with no gaps on either side.
	task automatic test_no_idle();
		src_idle_en = 1'b0;
		snk_idle_en = 1'b0;
		test_random_pixels(classic_view(16, 64), 60);
		src_idle_en = 1'b1;
		snk_idle_en = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Sequence
	// ------------------------------------------------------------------

	initial begin
		arst_n         <= 1'b0;
		psel           <= 1'b0;
		penable        <= 1'b0;
		pwrite         <= 1'b0;
		paddr          <= '0;
		pwdata         <= '0;
		pix_ch.valid   <= 1'b0;
		pix_ch.pixel_x <= '0;
		pix_ch.pixel_y <= '0;
		view_cfg.origin_re = mep_pkg::ORIGIN_RE_RST;
		view_cfg.origin_im = mep_pkg::ORIGIN_IM_RST;
		view_cfg.step_re   = mep_pkg::STEP_RE_RST;
		view_cfg.step_im   = mep_pkg::STEP_IM_RST;
		view_cfg.max_iter  = mep_pkg::MAX_ITER_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_view();
		test_field_extremes();
		test_escape_boundary();
		test_single_pass();
		test_backpressure();
		test_random_pixels(classic_view(16, 64), 80);
		test_random_pixels(zoom_view(), 70);
		test_random_pixels(wild_view(), 60);
		test_no_idle();

		// Give any stray word time to show up.
		repeat (TAIL_CYCLES) @(posedge clk);
		if (color_errors == 0 && expected_colors.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/mep_pkg.sv
rtl/core/mep_if.sv
rtl/core/mep_mul64.sv
rtl/core/mep_datapath.sv
rtl/core/mep_ctrl.sv
rtl/core/mandelbrot_escape_pixel.sv
bench/tb_mandelbrot_escape_pixel.sv
